[sv/compacting_array_list_unit_assert.svh]
// Assertion macros shared by the list unit.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef COMPACTING_ARRAY_LIST_UNIT_ASSERT_SVH
`define COMPACTING_ARRAY_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cal_pkg.sv]
// ----------------------------------------------------------------------------
// cal_pkg
// Types and constants shared by the modules of the compacting array list.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    localparam int IDX_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GET_WAIT,
        ST_SHIFT,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic judge;
        logic wr_append;
        logic wr_update;
        logic rd_get;
        logic get_capture;
        logic shift_start;
        logic shift_run;
        logic count_dec;
        logic result_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic req_ok;
        logic shift_more;
        logic shift_pend;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/compacting_array_list_unit.sv]
// ----------------------------------------------------------------------------
// compacting_array_list_unit
// Bounded, densely packed list of signed 32-bit words with append, update,
// remove and get commands; one result per command.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit first)          tuser
//  s_axis    in         index[7:0], value[39:8]        command[1:0]
//  m_axis    out        read_value[31:0],              status[1:0]
//                       count[38:32], zero[39]
//
// One command is worked at a time; the next is taken once the previous result
// sits in the output register, even if that result has not been taken yet.
// Append, update and rejected commands go from accept through execute to the
// result state; get adds a wait for the registered store read. Remove moves
// every entry above the index down by one, through the store's single read
// and write ports, before the count drops.
// Reset clears the entry count; the store needs no clearing.
// A stalled result holds in the output register and holds off the next result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compacting_array_list_unit_assert.svh"

module compacting_array_list_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // index[7:0], value[39:8]
    input  wire logic [cal_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command[1:0]
    input  wire logic [cal_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // read_value[31:0], count[38:32], zero[39]
    output logic      [cal_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic      [cal_pkg::STAT_W-1:0]        m_axis_tuser
);

    cal_pkg::dp_cmd_t             dp_cmd;
    cal_pkg::dp_stat_t            dp_stat;
    logic [cal_pkg::VAL_W-1:0]    read_value;
    logic [cal_pkg::COUNT_W-1:0]  count;

    cal_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    cal_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .in_command    (s_axis_tuser),
        .in_index      (s_axis_tdata[cal_pkg::IDX_W-1:0]),
        .in_value      (s_axis_tdata[cal_pkg::IDX_W +: cal_pkg::VAL_W]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_status    (m_axis_tuser),
        .out_read_value(read_value),
        .out_count     (count)
    );

    assign m_axis_tdata = {1'b0, count, read_value};

    `CAL_ASSERT_NEXT(a_one_at_a_time,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready,
        "item accepted while busy")
    `CAL_ASSERT_SAME(a_full_at_capacity,
        m_axis_tvalid && (m_axis_tuser == cal_pkg::STAT_FULL),
        count == cal_pkg::COUNT_W'(CAPACITY),
        "full reported below capacity")
    `CAL_ASSERT_SAME(a_reject_reads_zero,
        m_axis_tvalid && (m_axis_tuser != cal_pkg::STAT_OK),
        read_value == '0,
        "rejected command returned data")
    `CAL_ASSERT_SAME(a_status_code,
        m_axis_tvalid,
        (m_axis_tuser == cal_pkg::STAT_OK) || (m_axis_tuser == cal_pkg::STAT_FULL)
            || (m_axis_tuser == cal_pkg::STAT_BAD_INDEX),
        "undefined status code")

endmodule

`default_nettype wire

[sv/cal_ram.sv]
// ----------------------------------------------------------------------------
// cal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/cal_dp.sv]
// ----------------------------------------------------------------------------
// cal_dp
// Datapath of the list: command registers, entry count, shift pointers,
// entry store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cal_pkg::dp_cmd_t             cmd,
    output cal_pkg::dp_stat_t                 stat,
    input  wire logic [cal_pkg::CMD_W-1:0]    in_command,
    input  wire logic [cal_pkg::IDX_W-1:0]    in_index,
    input  wire logic [cal_pkg::VAL_W-1:0]    in_value,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [cal_pkg::STAT_W-1:0]   out_status,
    output logic      [cal_pkg::VAL_W-1:0]    out_read_value,
    output logic      [cal_pkg::COUNT_W-1:0]  out_count
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > cal_pkg::IDX_W) ? CW : cal_pkg::IDX_W;

    cal_pkg::cmd_t                 cmd_reg;
    logic [cal_pkg::IDX_W-1:0]     idx_reg;
    logic [cal_pkg::VAL_W-1:0]     val_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [CW-1:0]                 src_reg;
    logic [AW-1:0]                 dst_reg;
    logic                          pend_reg;
    cal_pkg::status_t              res_status_reg;
    logic [cal_pkg::VAL_W-1:0]     rdval_reg;
    logic                          out_valid_reg;
    cal_pkg::status_t              out_status_reg;
    logic [cal_pkg::VAL_W-1:0]     out_read_reg;
    logic [cal_pkg::COUNT_W-1:0]   out_count_reg;

    cal_pkg::status_t              req_status;
    logic                          list_full;
    logic                          bad_index;
    logic                          shift_more;
    logic                          shift_wr;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [cal_pkg::VAL_W-1:0]     ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [cal_pkg::VAL_W-1:0]     ram_rdata;

    assign list_full  = (count_reg == CW'(CAPACITY));
    assign bad_index  = (CMPW'(idx_reg) >= CMPW'(count_reg));
    assign shift_more = (src_reg < count_reg);
    assign shift_wr   = cmd.shift_run && pend_reg;

    always_comb
    begin
        if (cmd_reg == cal_pkg::CMD_APPEND)
        begin
            req_status = list_full ? cal_pkg::STAT_FULL : cal_pkg::STAT_OK;
        end
        else
        begin
            req_status = bad_index ? cal_pkg::STAT_BAD_INDEX : cal_pkg::STAT_OK;
        end
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.req_ok     = (req_status == cal_pkg::STAT_OK);
        stat.shift_more = shift_more;
        stat.shift_pend = pend_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Write port: append at the tail, update in place, or move an entry down
    // during a remove. Only one of them is active in any cycle.
    always_comb
    begin
        ram_we    = cmd.wr_append || cmd.wr_update || shift_wr;
        ram_wdata = val_reg;
        ram_waddr = dst_reg;
        priority if (cmd.wr_append)
        begin
            ram_waddr = count_reg[AW-1:0];
        end
        else if (cmd.wr_update)
        begin
            ram_waddr = idx_reg[AW-1:0];
        end
        else
        begin
            ram_wdata = ram_rdata;
        end
    end

    always_comb
    begin
        ram_re    = cmd.rd_get || (cmd.shift_run && shift_more);
        ram_raddr = cmd.rd_get ? idx_reg[AW-1:0] : src_reg[AW-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.wr_append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    cal_ram #(
        .WIDTH(cal_pkg::VAL_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.shift_start)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.shift_run)
            begin
                pend_reg <= shift_more;
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= cal_pkg::cmd_t'(in_command);
            idx_reg   <= in_index;
            val_reg   <= in_value;
            rdval_reg <= '0;
        end
        else if (cmd.get_capture)
        begin
            rdval_reg <= ram_rdata;
        end
        if (cmd.judge)
        begin
            res_status_reg <= req_status;
        end
        // The read pointer starts one entry ahead of the write pointer.
        if (cmd.shift_start)
        begin
            src_reg <= CW'(idx_reg) + CW'(1);
            dst_reg <= AW'(idx_reg);
        end
        else if (cmd.shift_run)
        begin
            if (shift_more)
            begin
                src_reg <= src_reg + CW'(1);
            end
            if (pend_reg)
            begin
                dst_reg <= dst_reg + AW'(1);
            end
        end
        if (cmd.result_load)
        begin
            out_status_reg <= res_status_reg;
            out_read_reg   <= rdval_reg;
            out_count_reg  <= cal_pkg::COUNT_W'(count_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_read_value = out_read_reg;
    assign out_count      = out_count_reg;

endmodule

`default_nettype wire

[sv/cal_ctrl.sv]
// ----------------------------------------------------------------------------
// cal_ctrl
// Controller of the list: sequences one command at a time through the
// datapath and hands its result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cal_pkg::dp_stat_t stat,
    output cal_pkg::dp_cmd_t       cmd
);

    cal_pkg::state_t state_reg;
    cal_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cal_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cal_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cal_pkg::ST_EXEC;
                end
            end
            cal_pkg::ST_EXEC:
            begin
                if (!stat.req_ok)
                begin
                    state_next = cal_pkg::ST_RESP;
                end
                else
                begin
                    unique case (stat.cmd)
                        cal_pkg::CMD_GET:    state_next = cal_pkg::ST_GET_WAIT;
                        cal_pkg::CMD_REMOVE: state_next = cal_pkg::ST_SHIFT;
                        default:             state_next = cal_pkg::ST_RESP;
                    endcase
                end
            end
            cal_pkg::ST_GET_WAIT:
            begin
                state_next = cal_pkg::ST_RESP;
            end
            cal_pkg::ST_SHIFT:
            begin
                if (!stat.shift_more && !stat.shift_pend)
                begin
                    state_next = cal_pkg::ST_RESP;
                end
            end
            cal_pkg::ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = cal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            cal_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            cal_pkg::ST_EXEC:
            begin
                cmd.judge = 1'b1;
                if (stat.req_ok)
                begin
                    unique case (stat.cmd)
                        cal_pkg::CMD_APPEND: cmd.wr_append   = 1'b1;
                        cal_pkg::CMD_UPDATE: cmd.wr_update   = 1'b1;
                        cal_pkg::CMD_REMOVE: cmd.shift_start = 1'b1;
                        cal_pkg::CMD_GET:    cmd.rd_get      = 1'b1;
                        default:             cmd.judge       = 1'b1;
                    endcase
                end
            end
            cal_pkg::ST_GET_WAIT:
            begin
                cmd.get_capture = 1'b1;
            end
            cal_pkg::ST_SHIFT:
            begin
                // The count drops once the last moved entry has been written.
                cmd.shift_run = 1'b1;
                cmd.count_dec = !stat.shift_more && !stat.shift_pend;
            end
            cal_pkg::ST_RESP:
            begin
                cmd.result_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
